[rtl/core/ldf_pkg.sv]
// Shared types and constants of the length-prefixed deframer.
`default_nettype none
package ldf_pkg;

	localparam int HEADER_BYTES_DEF = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd8192;

	localparam logic REG_PROTOCOL_MARK = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_ERROR,
		KIND_BURST
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} entry_t;

endpackage
`default_nettype wire

[rtl/core/ldf_front.sv]
// Front end: takes stream bytes, collects and checks the header, queues work.
`default_nettype none
module ldf_front #(
	parameter int HEADER_BYTES = ldf_pkg::HEADER_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid,
	output logic                stall,
	input  wire logic [7:0]     byte_in,
	input  wire logic           chunk_end,
	input  wire logic [7:0]     protocol_mark,
	input  wire logic [15:0]    max_message_length,
	input  wire logic           q_full,
	output logic                q_push,
	output ldf_pkg::entry_t     q_entry,
	input  wire logic           burst_done,
	output logic                locked,
	output logic [7:0]          hdr [HEADER_BYTES]
);
	import ldf_pkg::*;

	localparam int CNT_W = $clog2(HEADER_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_DISCARD
	} phase_t;

	phase_t            phase_q;
	logic [CNT_W-1:0]  count_q;
	logic [15:0]       remaining_q;
	logic              lock_q;
	logic [7:0]        store_q [HEADER_BYTES];
	logic [7:0]        view [HEADER_BYTES];
	logic              accept;
	logic              hdr_done;
	logic [15:0]       len_lo;
	logic              hdr_bad;
	logic [15:0]       body_len;
	logic [15:0]       rem_dec;

	assign stall  = lock_q || q_full;
	assign accept = valid && !stall;
	assign locked = lock_q;
	assign hdr    = store_q;

	always_comb begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			view[i] = (CNT_W'(i) == count_q) ? byte_in : store_q[i];
		end
	end

	assign hdr_done = (count_q == CNT_W'(HEADER_BYTES - 1));
	assign len_lo   = {view[3], view[2]};
	assign hdr_bad  = (view[0] != protocol_mark) || (view[4] != 8'd0) || (view[5] != 8'd0)
		|| (len_lo < 16'(HEADER_BYTES)) || (len_lo > max_message_length);
	assign body_len = len_lo - 16'(HEADER_BYTES);
	assign rem_dec  = (remaining_q != 16'd0) ? remaining_q - 16'd1 : 16'd0;

	always_comb begin
		q_push        = 1'b0;
		q_entry.kind  = KIND_BYTE;
		q_entry.data  = byte_in;
		q_entry.last  = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_BODY: begin
					q_push       = 1'b1;
					q_entry.last = (rem_dec == 16'd0);
				end
				PH_DISCARD: begin
					q_push = 1'b0;
				end
				default: begin
					if (hdr_done) begin
						q_push = 1'b1;
						if (hdr_bad) begin
							q_entry.kind = KIND_ERROR;
							q_entry.data = 8'd0;
						end else begin
							q_entry.kind = KIND_BURST;
							q_entry.last = (body_len == 16'd0);
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (phase_q != PH_BODY) && (phase_q != PH_DISCARD)) begin
			store_q[count_q] <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			count_q     <= '0;
			remaining_q <= '0;
			lock_q      <= 1'b0;
		end else begin
			if (burst_done) begin
				lock_q <= 1'b0;
			end
			if (accept) begin
				unique case (phase_q)
					PH_DISCARD: begin
						if (chunk_end) begin
							phase_q <= PH_HEADER;
							count_q <= '0;
						end
					end
					PH_BODY: begin
						remaining_q <= rem_dec;
						if (rem_dec == 16'd0) begin
							phase_q <= PH_HEADER;
							count_q <= '0;
						end
					end
					default: begin
						phase_q <= PH_HEADER;
						if (!hdr_done) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							count_q <= '0;
							if (hdr_bad) begin
								phase_q <= chunk_end ? PH_HEADER : PH_DISCARD;
							end else begin
								remaining_q <= body_len;
								lock_q      <= 1'b1;
								phase_q     <= (body_len != 16'd0) ? PH_BODY : PH_HEADER;
							end
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/ldf_queue.sv]
// Short register queue between the front end and the back end.
`default_nettype none
module ldf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ldf_pkg::entry_t push_entry,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output ldf_pkg::entry_t     head
);
	import ldf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [PTR_W:0]    count_q;
	logic              do_pop;

	assign full       = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/ldf_back.sv]
// Back end: drains the queue, plays out header bursts, drives the result register.
`default_nettype none
module ldf_back #(
	parameter int HEADER_BYTES = ldf_pkg::HEADER_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire ldf_pkg::entry_t head,
	output logic                pop,
	input  wire logic [7:0]     hdr [HEADER_BYTES],
	output logic                burst_done,
	output logic                result_valid,
	input  wire logic           result_stall,
	output logic [7:0]          byte_out,
	output logic                message_last,
	output logic                header_error
);
	import ldf_pkg::*;

	localparam int CNT_W = $clog2(HEADER_BYTES);

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_err_q;
	logic [CNT_W-1:0]  idx_q;
	logic              out_free;
	logic              load;
	logic              idx_end;
	logic [7:0]        nxt_byte;
	logic              nxt_last;
	logic              nxt_err;

	assign out_free = !out_valid_q || !result_stall;
	assign load     = head_valid && out_free;
	assign idx_end  = (idx_q == CNT_W'(HEADER_BYTES - 1));

	always_comb begin
		nxt_byte   = head.data;
		nxt_last   = head.last;
		nxt_err    = 1'b0;
		pop        = load;
		burst_done = 1'b0;
		unique case (head.kind)
			KIND_BYTE: begin
				nxt_err = 1'b0;
			end
			KIND_ERROR: begin
				nxt_byte = 8'd0;
				nxt_last = 1'b0;
				nxt_err  = 1'b1;
			end
			KIND_BURST: begin
				nxt_byte   = hdr[idx_q];
				nxt_last   = head.last && idx_end;
				pop        = load && idx_end;
				burst_done = load && idx_end;
			end
			default: begin
				nxt_err = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= nxt_byte;
				out_last_q  <= nxt_last;
				out_err_q   <= nxt_err;
				if (head.kind == KIND_BURST) begin
					idx_q <= idx_end ? '0 : idx_q + CNT_W'(1);
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign byte_out     = out_byte_q;
	assign message_last = out_last_q;
	assign header_error = out_err_q;

endmodule
`default_nettype wire

[rtl/core/length_prefixed_deframer.sv]
// Top level of the length-prefixed message deframer.
// Input channel: one stream byte per transfer (valid/stall, byte_in, chunk_end).
// Output channel: one result per transfer (result_valid/result_stall, byte_out,
// message_last, header_error). Registers are written through write_enable,
// reg_index and write_data: index 0 is the protocol mark, index 1 the maximum
// total message length.
// A body byte or an error result passes through the queue and then the result
// register before it can transfer out. Body bytes flow at one per cycle while
// neither the input nor the receiver stalls. A good header is played out as
// HEADER_BYTES results from the header registers, one per cycle while the
// receiver keeps up; the input is stalled from the transfer that completes the
// header until the last burst byte has been loaded into the result register.
// A four-entry queue separates the front end from the result register, so a
// stalled receiver backs up the queue first, then stalls the input.
// Reset empties the queue and the result register, clears the header position
// and returns the registers to mark 0 and maximum 8192.
`default_nettype none
module length_prefixed_deframer #(
	parameter int HEADER_BYTES = ldf_pkg::HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        chunk_end,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       byte_out,
	output logic             message_last,
	output logic             header_error,
	input  wire logic        write_enable,
	input  wire logic        reg_index,
	input  wire logic [15:0] write_data
);
	import ldf_pkg::*;

	logic [7:0]   protocol_mark_q;
	logic [15:0]  max_length_q;
	logic         q_full;
	logic         q_push;
	entry_t       q_entry;
	logic         q_pop;
	logic         head_valid;
	entry_t       head;
	logic         burst_done;
	logic         locked;
	logic [7:0]   hdr [HEADER_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_mark_q <= '0;
			max_length_q    <= MAX_LENGTH_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_PROTOCOL_MARK: protocol_mark_q <= write_data[7:0];
				REG_MAX_LENGTH:    max_length_q    <= write_data;
				default:           max_length_q    <= max_length_q;
			endcase
		end
	end

	ldf_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid             (valid),
		.stall             (stall),
		.byte_in           (byte_in),
		.chunk_end         (chunk_end),
		.protocol_mark     (protocol_mark_q),
		.max_message_length(max_length_q),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_entry           (q_entry),
		.burst_done        (burst_done),
		.locked            (locked),
		.hdr               (hdr)
	);

	ldf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(head_valid),
		.head      (head)
	);

	ldf_back #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (q_pop),
		.hdr         (hdr),
		.burst_done  (burst_done),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.byte_out    (byte_out),
		.message_last(message_last),
		.header_error(header_error)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_done_only_when_locked: assert property (@(posedge clk) disable iff (!arst_n)
		burst_done |-> locked)
		else $error("burst finished without a held header");

	a_error_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && header_error) |-> (byte_out == 8'd0 && !message_last))
		else $error("error result carries data");

endmodule
`default_nettype wire

[tb/length_prefixed_deframer_test.sv]
// Testbench for the length-prefixed deframer: directed and random byte streams against a predictor.
module length_prefixed_deframer_test;
	import ldf_pkg::*;

	localparam int HDR = HEADER_BYTES_DEF;
	localparam int SETTLE_CYCLES = HDR + 12;
	localparam int LIMIT_CYCLES = 600000;

	typedef enum logic [1:0] {
		COLLECT_HEADER,
		PASS_BODY,
		DISCARD_CHUNK
	} deframe_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} deframed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid;
	logic        stall;
	logic [7:0]  byte_in;
	logic        chunk_end;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  byte_out;
	logic        message_last;
	logic        header_error;
	logic        write_enable;
	logic        reg_index;
	logic [15:0] write_data;

	length_prefixed_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.stall(stall),
		.byte_in(byte_in),
		.chunk_end(chunk_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.byte_out(byte_out),
		.message_last(message_last),
		.header_error(header_error),
		.write_enable(write_enable),
		.reg_index(reg_index),
		.write_data(write_data)
	);

	// predictor state and register copies
	logic [7:0]     hdr_bytes [0:HDR-1];
	int             hdr_count = 0;
	logic [15:0]    body_left = '0;
	deframe_phase_t phase = COLLECT_HEADER;
	logic [7:0]     mark = 8'h00;
	logic [15:0]    max_len = MAX_LENGTH_RESET;

	deframed_t expected_results[$];

	int  mismatches = 0;
	int  bytes_sent = 0;
	int  items_counted = 0;
	int  messages_seen = 0;
	int  headers_rejected = 0;
	int  results_taken = 0;
	int  taken_seen = 0;
	int  hold_left = 0;
	int  cycle_count = 0;
	bit  send_idle = 1'b0;
	bit  recv_idle = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void push_result(input logic [7:0] d, input logic l, input logic e);
		deframed_t r;
		r.data = d;
		r.last = l;
		r.err = e;
		expected_results.push_back(r);
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic e);
		logic [31:0] total_len;
		int i;
		if (phase == DISCARD_CHUNK) begin
			if (e) begin
				phase = COLLECT_HEADER;
				hdr_count = 0;
			end
			return;
		end
		items_counted++;
		if (phase == PASS_BODY) begin
			body_left = body_left - 16'd1;
			push_result(b, body_left == 0, 1'b0);
			if (body_left == 0) begin
				phase = COLLECT_HEADER;
				hdr_count = 0;
			end
			return;
		end
		hdr_bytes[hdr_count] = b;
		hdr_count++;
		if (hdr_count < HDR)
			return;
		hdr_count = 0;
		total_len = {hdr_bytes[5], hdr_bytes[4], hdr_bytes[3], hdr_bytes[2]};
		if (hdr_bytes[0] != mark || total_len < HDR || total_len > max_len) begin
			push_result(8'h00, 1'b0, 1'b1);
			phase = e ? COLLECT_HEADER : DISCARD_CHUNK;
			return;
		end
		body_left = 16'(total_len - 32'(HDR));
		for (i = 0; i < HDR; i++)
			push_result(hdr_bytes[i], i == HDR - 1 && body_left == 0, 1'b0);
		phase = (body_left != 0) ? PASS_BODY : COLLECT_HEADER;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		gap = send_idle ? $urandom_range(0, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		valid <= 1'b1;
		byte_in <= b;
		chunk_end <= e;
		@(posedge clk);
		while (stall !== 1'b0) @(posedge clk);
		bytes_sent++;
		deframe_byte(b, e);
	endtask

	task automatic drain_results();
		@(negedge clk);
		valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		@(negedge clk);
		write_enable <= 1'b0;
		if (idx == REG_PROTOCOL_MARK)
			mark = val[7:0];
		else
			max_len = val;
	endtask

	task automatic configure(input logic [7:0] m, input logic [15:0] limit);
		drain_results();
		write_reg(REG_PROTOCOL_MARK, {8'h00, m});
		write_reg(REG_MAX_LENGTH, limit);
	endtask

	task automatic send_header(input logic [7:0] first, input logic [31:0] total, input int split);
		logic [7:0] hdr [0:HDR-1];
		int i;
		for (i = 0; i < HDR; i++)
			hdr[i] = $urandom_range(0, 255);
		hdr[0] = first;
		hdr[2] = total[7:0];
		hdr[3] = total[15:8];
		hdr[4] = total[23:16];
		hdr[5] = total[31:24];
		for (i = 0; i < HDR; i++)
			send_byte(hdr[i], split ? $urandom_range(0, 5) == 0 : 1'b0);
	endtask

	task automatic send_message(input bit well_formed);
		logic [31:0] total;
		logic [7:0]  first;
		int          i, n;
		first = mark;
		if (well_formed) begin
			total = HDR + $urandom_range(0, 24);
			if ($urandom_range(0, 7) == 0 && max_len <= 200)
				total = max_len;
			else if ($urandom_range(0, 7) == 0)
				total = HDR;
			if (max_len >= HDR && total > max_len)
				total = max_len;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					first = mark ^ 8'($urandom_range(1, 255));
					total = HDR + $urandom_range(0, 10);
				end
				1: total = $urandom_range(0, HDR - 1);
				2: total = 32'(max_len) + 1 + $urandom_range(0, 40);
				default: total = $urandom;
			endcase
		end
		send_header(first, total, 1);
		while (phase == PASS_BODY)
			send_byte($urandom_range(0, 255), $urandom_range(0, 5) == 0);
		if (!well_formed) begin
			n = $urandom_range(0, 6);
			for (i = 0; i < n; i++)
				send_byte($urandom_range(0, 255), $urandom_range(0, 2) == 0);
		end
	endtask

	task automatic run_traffic(input int target);
		int start, pick, i, n;
		start = items_counted;
		while (items_counted - start < target) begin
			send_idle = $urandom_range(0, 2) != 0;
			recv_idle = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 15) == 0)
				drain_results();
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				// realign to a header boundary
				while (phase != COLLECT_HEADER || hdr_count != 0)
					send_byte($urandom_range(0, 255), 1'b1);
				send_message(1'b1);
			end else if (pick <= 8) begin
				send_message(1'b0);
			end else begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_byte($urandom_range(0, 255), $urandom_range(0, 1));
			end
		end
	endtask

	task automatic test_minimal_message();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_short_length();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_header(8'h00, HDR - 1, 0);
		send_byte(8'h00, 1'b1);
		send_header(8'h00, HDR + 1, 0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_rejected_header_discard();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_header(8'h01, HDR + 10, 0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_narrow_limit();
		configure(8'hA5, 16'd60);
		run_traffic(130);
	endtask

	task automatic test_full_range();
		configure(8'hFF, 16'hFFFF);
		run_traffic(110);
	endtask

	task automatic test_header_only_limit();
		configure(8'h00, HDR);
		run_traffic(70);
	endtask

	task automatic test_limit_below_header();
		configure(8'h5A, HDR - 1);
		run_traffic(40);
	endtask

	task automatic test_default_limit();
		configure(8'h3C, MAX_LENGTH_RESET);
		run_traffic(80);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (results_taken != taken_seen) begin
			taken_seen = results_taken;
			hold_left = recv_idle ? $urandom_range(0, 18) : 0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			result_stall <= 1'b0;
	end

	always @(posedge clk) begin
		deframed_t want;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			results_taken++;
			if (message_last === 1'b1)
				messages_seen++;
			if (header_error === 1'b1)
				headers_rejected++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transfer, got byte %02h last %b error %b",
					$time, byte_out, message_last, header_error);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (byte_out !== want.data) begin
					$display("%0t: byte_out expected %02h, got %02h", $time, want.data, byte_out);
					mismatches++;
				end
				if (message_last !== want.last) begin
					$display("%0t: message_last expected %b, got %b",
						$time, want.last, message_last);
					mismatches++;
				end
				if (header_error !== want.err) begin
					$display("%0t: header_error expected %b, got %b",
						$time, want.err, header_error);
					mismatches++;
				end
			end
		end
	end

	initial begin
		valid = 1'b0;
		byte_in = 8'h00;
		chunk_end = 1'b0;
		write_enable = 1'b0;
		reg_index = REG_PROTOCOL_MARK;
		write_data = 16'h0000;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_minimal_message();
		test_short_length();
		test_rejected_header_discard();
		test_narrow_limit();
		test_full_range();
		test_header_only_limit();
		test_limit_below_header();
		test_default_limit();
		drain_results();

		$display("Streamed %0d bytes (%0d outside discarded chunks) over six register settings,",
			bytes_sent, items_counted);
		$display("with %0d complete messages and %0d rejected headers received.",
			messages_seen, headers_rejected);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
